// ----- src/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [MODE_W-1:0] MODE_SORTED_INS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POS_INS    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VALUE_REM  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POS_REM    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

    // What each cell tests to decide whether it is the selected slot.
    typedef enum logic [1:0] {
        MATCH_NOT_LESS,
        MATCH_POSITION,
        MATCH_EQUAL
    } match_kind_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        match_kind_t               kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        logic                      ins_en;
        logic                      rem_en;
    } cell_cmd_t;

endpackage

// ----- src/bole_cell.sv -----
// One storage cell of the ordered list row with its local compare and shift logic.
`timescale 1ns / 1ps

module bole_cell #(
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic                               aclk,
    input  bole_pkg::cell_cmd_t                cmd,
    input  logic [CNT_W-1:0]                   count,
    input  logic                               seen_in,
    output logic                               seen_out,
    input  logic signed [bole_pkg::VALUE_W-1:0] left_value,
    input  logic signed [bole_pkg::VALUE_W-1:0] right_value,
    output logic signed [bole_pkg::VALUE_W-1:0] entry_value
);
    import bole_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
    localparam logic [POS_W:0]   POS_C = (POS_W + 1)'(INDEX + 1);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occupied;
    logic                      hit;

    assign occupied = count > IDX_C;

    always_comb begin
        case (cmd.kind)
            MATCH_NOT_LESS: hit = !occupied || !(entry_reg < cmd.value);
            MATCH_POSITION: hit = ({1'b0, cmd.pos} == POS_C);
            MATCH_EQUAL:    hit = occupied && (entry_reg == cmd.value);
            default:        hit = 1'b0;
        endcase
    end

    assign seen_out = seen_in | hit;

    // On insert, cells past the slot take the left neighbor and the slot takes
    // the new value; on removal, the slot and every cell past it take the right one.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins_en) begin
            if (seen_in) begin
                entry_next = left_value;
            end else if (hit) begin
                entry_next = cmd.value;
            end
        end else if (cmd.rem_en) begin
            if (seen_out) begin
                entry_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;

endmodule

// ----- src/bounded_ordered_list_engine_core.sv -----
// Top level of the bounded ordered list engine: command decode, cell row and result register.
// The result of a request is registered and is valid in the cycle after it is accepted.
// One request per cycle while no result is pending or it is taken; the whole cell row compares and shifts at once,
// and the selection flag ripples through the row within that cycle.
// The output register frees up when its result is taken, so a new request may be
// accepted in the same cycle that the previous result leaves.
// Reset (synchronous, active low) empties the list and drops any pending result.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core #(
    parameter int CAPACITY = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bole_pkg::MODE_W-1:0]           s_mode,
    input  logic signed [bole_pkg::VALUE_W-1:0]   s_item_value,
    input  logic [bole_pkg::POS_W-1:0]            s_position,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bole_pkg::STATUS_W-1:0]         m_status,
    output logic                                  m_found,
    output logic [bole_pkg::COUNT_W-1:0]          m_element_count
);
    import bole_pkg::*;

    // The count must be able to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_found_reg;
    logic [COUNT_W-1:0]  m_element_count_reg;

    logic                accept;
    logic                list_full;
    logic                any_hit;
    logic [POS_W:0]      pos_ext;
    logic [POS_W:0]      count_ext;
    logic                ins_pos_ok;
    logic                rem_pos_ok;
    logic [STATUS_W-1:0] status;
    logic                found;
    cell_cmd_t           cmd;
    match_kind_t         kind;
    logic                ins_ok;
    logic                rem_ok;

    // Selection flags and stored values along the row.
    logic [CAPACITY:0]                seen;
    logic signed [VALUE_W-1:0]        entries [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign list_full  = (count_reg == FULL_C);
    assign pos_ext    = {1'b0, s_position};
    assign count_ext  = (POS_W + 1)'(count_reg);
    assign ins_pos_ok = (s_position != '0) && (pos_ext <= count_ext + 1'b1);
    assign rem_pos_ok = (s_position != '0) && (pos_ext <= count_ext);
    assign any_hit    = seen[CAPACITY];

    // Decode the request. The match kind depends on the mode alone, so the
    // cells' hit chain never depends on the enables derived from it.
    always_comb begin
        kind   = MATCH_EQUAL;
        status = ST_OK;
        found  = 1'b0;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        case (s_mode)
            MODE_SORTED_INS: begin
                kind = MATCH_NOT_LESS;
                if (list_full) begin
                    status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_POS_INS: begin
                kind = MATCH_POSITION;
                if (list_full) begin
                    status = ST_FULL;
                end else if (!ins_pos_ok) begin
                    status = ST_BAD_POS;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            MODE_VALUE_REM: begin
                kind = MATCH_EQUAL;
                if (!any_hit) begin
                    status = ST_NOT_FOUND;
                end else begin
                    rem_ok = 1'b1;
                end
            end
            MODE_POS_REM: begin
                kind = MATCH_POSITION;
                if (!rem_pos_ok) begin
                    status = ST_BAD_POS;
                end else begin
                    rem_ok = 1'b1;
                end
            end
            MODE_LOOKUP: begin
                kind  = MATCH_EQUAL;
                found = any_hit;
            end
            default: begin
                kind = MATCH_EQUAL;
            end
        endcase
    end

    always_comb begin
        cmd.kind   = kind;
        cmd.value  = s_item_value;
        cmd.pos    = s_position;
        cmd.ins_en = accept && ins_ok;
        cmd.rem_en = accept && rem_ok;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.rem_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign seen[0] = 1'b0;

    // The row of cells: each hands its value to both neighbors and passes the
    // "slot already selected" flag to the right.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_v;
        logic signed [VALUE_W-1:0] right_v;

        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_inner_l
            assign left_v = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_inner_r
            assign right_v = entries[i+1];
        end

        bole_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .count       (count_reg),
            .seen_in     (seen[i]),
            .seen_out    (seen[i+1]),
            .left_value  (left_v),
            .right_value (right_v),
            .entry_value (entries[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it needs no reset since m_valid qualifies it.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg        <= status;
            m_found_reg         <= found;
            m_element_count_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found         = m_found_reg;
    assign m_element_count = m_element_count_reg;

endmodule
